@@ src/qlc_pkg.sv @@
`timescale 1ns / 1ps
package qlc_pkg;

    localparam int PosW = 32;
    localparam int LatW = 24;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_CHANGE  = 2'd1,
        REQ_ABORT   = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_t;

    // Classified work handed from the front to the back.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_START,
        OP_ABORT,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [PosW-1:0]   var_val;
        logic              mode;
        logic [PosW-1:0]   span_len;
        logic [LatW-1:0]   cur_lat;
        logic [LatW-1:0]   tgt_lat;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_M1,
        ST_M2,
        ST_P,
        ST_M3,
        ST_M4,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

@@ src/quintic_lane_change_trajectory.sv @@
`timescale 1ns / 1ps
// Channel  Handshake              Fields
// in       valid / stall          req_type time_now pos_now mode span_length current_lat
//                                 target_lat
// out      out_valid / out_stall  reference pending accepted
// A request, an abort, an unused code or a tick that needs no evaluation goes from the
// queue straight to the output state. A tick inside an open span leaves the queue, runs
// 32 restoring divider steps and six product, polynomial and finish steps (four of them
// on the shared multiplier), then presents the result.
// The back handles one transaction at a time and holds its result until it is taken;
// while the output is stalled the two-entry queue fills and then raises stall.
// Reset is asynchronous and clears all control and trajectory state.
module quintic_lane_change_trajectory (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic [1:0]         req_type,
    input  logic [31:0]        time_now,
    input  logic [31:0]        pos_now,
    input  logic               mode,
    input  logic [31:0]        span_length,
    input  logic signed [23:0] current_lat,
    input  logic signed [23:0] target_lat,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] reference,
    output logic               pending,
    output logic               accepted
);
    import qlc_pkg::*;

    logic q_valid, q_pop, kind;
    cmd_t q_head;

    // The front classifies transactions; the back runs the profile arithmetic.
    qlc_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .req_type(req_type), .time_now(time_now), .pos_now(pos_now), .mode(mode),
        .span_length(span_length), .current_lat(current_lat), .target_lat(target_lat),
        .span_kind(kind), .q_valid(q_valid), .q_pop(q_pop),
        .q_head(q_head)
    );

    qlc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
        .span_kind(kind), .out_valid(out_valid), .out_stall(out_stall),
        .reference(reference), .pending(pending), .accepted(accepted)
    );

endmodule

@@ src/qlc_front.sv @@
`timescale 1ns / 1ps
module qlc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid,
    output logic                   stall,
    input  logic [1:0]             req_type,
    input  logic [31:0]            time_now,
    input  logic [31:0]            pos_now,
    input  logic                   mode,
    input  logic [31:0]            span_length,
    input  logic signed [23:0]     current_lat,
    input  logic signed [23:0]     target_lat,
    input  logic                   span_kind,
    output logic                   q_valid,
    input  logic                   q_pop,
    output qlc_pkg::cmd_t          q_head
);
    import qlc_pkg::*;

    // The back pops in order, so the span kind it holds at pop time is the one that
    // applies to the head; ticks pick their evaluation variable from it at the head.
    cmd_t            mem_reg [QueueDepth];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    cmd_t            new_cmd;
    logic            push;

    always_comb
    begin
        new_cmd.mode     = mode;
        new_cmd.span_len = span_length;
        new_cmd.cur_lat  = current_lat;
        new_cmd.tgt_lat  = target_lat;
        new_cmd.var_val  = mode ? time_now : pos_now;
        unique case (req_t'(req_type))
            REQ_TICK:   new_cmd.op = OP_TICK;
            REQ_CHANGE: new_cmd.op = OP_START;
            REQ_ABORT:  new_cmd.op = OP_ABORT;
            default:    new_cmd.op = OP_HOLD;
        endcase
        // Ticks store both candidates folded: keep time in var_val, position in span_len.
        if (req_t'(req_type) == REQ_TICK)
        begin
            new_cmd.var_val  = time_now;
            new_cmd.span_len = pos_now;
        end
    end

    assign stall = (cnt_reg == 2'(QueueDepth));
    assign push  = valid && !stall;
    assign q_valid = (cnt_reg != 2'd0);
    always_comb
    begin
        q_head = mem_reg[rd_ptr_reg];
        if (q_head.op == OP_TICK)
            q_head.var_val = span_kind ? mem_reg[rd_ptr_reg].var_val
                                       : mem_reg[rd_ptr_reg].span_len;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= new_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QueueDepth))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QueueDepth)) |-> !push)
        else $error("push into full queue");

endmodule

@@ src/qlc_back.sv @@
`timescale 1ns / 1ps
module qlc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  qlc_pkg::cmd_t          q_head,
    output logic                   span_kind,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [23:0]     reference,
    output logic                   pending,
    output logic                   accepted
);
    import qlc_pkg::*;

    state_t               state_reg, state_next;
    logic                 busy_reg, begun_reg, kind_reg;
    logic [31:0]          start_reg, span_reg;
    logic [32:0]          end_reg;
    logic signed [23:0]   lat_s_reg, lat_e_reg, hold_reg;
    logic                 acc_reg;

    // Shared datapath registers.
    logic [31:0]          rem_reg;
    logic [31:0]          quo_reg;
    logic [5:0]           cnt_reg;
    logic [31:0]          s_reg, s2_reg, s3_reg;
    logic [31:0]          p_reg;
    logic [32:0]          h_reg;
    logic [63:0]          prod_reg;

    logic [31:0]          el_now;
    logic                 beg_now;
    logic                 at_end;
    logic                 start_ok;
    logic                 run_tick;
    logic [32:0]          shl;
    logic [32:0]          dif;
    logic                 ge;
    logic [35:0]          p_full;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic [24:0]          delta;
    logic [24:0]          mag;
    logic                 neg;
    logic [63:0]          mq;
    logic [24:0]          q_mag;
    logic signed [25:0]   q_s;
    logic signed [25:0]   sum;

    assign span_kind = kind_reg;

    assign beg_now  = begun_reg || (q_head.var_val >= start_reg);
    assign el_now   = (q_head.var_val >= start_reg) ? q_head.var_val - start_reg : 32'd0;
    assign at_end   = ({1'b0, q_head.var_val} >= end_reg);
    assign start_ok = !busy_reg && (q_head.span_len != 32'd0);
    assign run_tick = (q_head.op == OP_TICK) && busy_reg && !at_end && beg_now;

    // Restoring division step: the remainder stays below the span.
    assign shl = {rem_reg, 1'b0};
    assign dif = shl - {1'b0, span_reg};
    assign ge  = (shl >= {1'b0, span_reg});

    assign p_full = {4'd10, 32'd0} + 36'(s2_reg) * 36'd6 - 36'(s_reg) * 36'd15;

    assign delta = 25'(lat_e_reg) - 25'(lat_s_reg);
    assign neg   = delta[24];
    assign mag   = neg ? (~delta + 25'd1) : delta;

    // One 32 x 32 multiplier shared by all product steps.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_M1:
            begin
                mul_a = quo_reg;
                mul_b = quo_reg;
            end
            ST_M2:
            begin
                mul_a = prod_reg[63:32];
                mul_b = s_reg;
            end
            ST_M3:
            begin
                mul_a = s3_reg;
                mul_b = p_reg;
            end
            ST_FIN:
            begin
                mul_a = 32'(mag);
                mul_b = h_reg[31:0];
            end
            default: ;
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);
    // h at its cap of 1.0 has only bit 32 set, which adds mag * 2^32.
    assign mq    = mul_p + (h_reg[32] ? {7'd0, mag, 32'd0} : 64'd0);
    assign q_mag = mq[56:32] + 25'(mq[31]);
    assign q_s   = signed'({1'b0, q_mag});
    assign sum   = 26'(lat_s_reg) + (neg ? -q_s : q_s);

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = run_tick ? ST_DIV : ST_OUT;
                end
            ST_DIV:
                if (cnt_reg == 6'd1)
                    state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_P;
            ST_P:    state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:
                if (!out_stall)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
            s_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            p_reg <= '0;
            h_reg <= '0;
            prod_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (q_valid)
                    begin
                        // Dividend is elapsed * 2^32; elapsed below the span keeps
                        // the quotient within 32 bits.
                        rem_reg <= el_now;
                        quo_reg <= '0;
                        cnt_reg <= 6'd32;
                    end
                ST_DIV:
                begin
                    rem_reg <= ge ? dif[31:0] : shl[31:0];
                    quo_reg <= {quo_reg[30:0], ge};
                    cnt_reg <= cnt_reg - 6'd1;
                end
                ST_M1:
                begin
                    s_reg    <= quo_reg;
                    prod_reg <= mul_p;
                end
                ST_M2:
                begin
                    s2_reg   <= prod_reg[63:32];
                    prod_reg <= mul_p;
                end
                ST_P:
                begin
                    s3_reg <= prod_reg[63:32];
                    p_reg  <= p_full[35:4];
                end
                ST_M3: prod_reg <= mul_p;
                ST_M4: h_reg <= (prod_reg[63:28] > 36'h1_0000_0000) ? 33'h1_0000_0000
                                : prod_reg[60:28];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg <= 1'b0; begun_reg <= 1'b0; kind_reg <= 1'b0;
            start_reg <= '0; span_reg <= '0; end_reg <= '0;
            lat_s_reg <= '0; lat_e_reg <= '0; hold_reg <= '0;
            acc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && q_valid)
            begin
                acc_reg <= (q_head.op == OP_START) && start_ok;
                unique case (q_head.op)
                    OP_START:
                        if (start_ok)
                        begin
                            busy_reg <= 1'b1; begun_reg <= 1'b0;
                            kind_reg <= q_head.mode;
                            start_reg <= q_head.var_val;
                            span_reg <= q_head.span_len;
                            end_reg <= 33'(q_head.var_val) + 33'(q_head.span_len);
                            lat_s_reg <= q_head.cur_lat; lat_e_reg <= q_head.tgt_lat;
                            hold_reg <= q_head.cur_lat;
                        end
                    OP_ABORT:
                    begin
                        busy_reg <= 1'b0;
                        hold_reg <= lat_s_reg;
                    end
                    OP_TICK:
                        if (busy_reg)
                        begin
                            begun_reg <= beg_now;
                            if (at_end)
                            begin
                                busy_reg <= 1'b0;
                                hold_reg <= lat_e_reg;
                            end
                            else
                                hold_reg <= lat_s_reg;
                        end
                    OP_HOLD: ;
                endcase
            end
            else if (state_reg == ST_FIN)
                hold_reg <= (sum > 26'sd8388607) ? 24'sh7FFFFF
                          : (sum < -26'sd8388608) ? 24'sh800000 : sum[23:0];
        end
    end

    assign out_valid = (state_reg == ST_OUT);
    assign reference = hold_reg;
    assign pending   = busy_reg;
    assign accepted  = acc_reg;

    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !q_pop)
        else $error("pop while a result is shown");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_stall) |=> state_reg == ST_OUT)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n) accepted |-> pending)
        else $error("accepted without pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> cnt_reg != 6'd0)
        else $error("divider step count exhausted");

endmodule

@@ test/quintic_lane_change_trajectory_test.sv @@
`timescale 1ns / 1ps
module quintic_lane_change_trajectory_test;
    import qlc_pkg::*;

    // One input transaction as the driver presents it.
    typedef struct {
        req_t              req;
        logic [31:0]       t_now;
        logic [31:0]       x_now;
        logic              md;
        logic [31:0]       len;
        logic signed [23:0] cur;
        logic signed [23:0] tgt;
    } lane_cmd_t;

    // One result transaction as the block should deliver it.
    typedef struct {
        logic signed [23:0] ref_lat;
        logic               pend;
        logic               acc;
    } lane_ref_t;

    localparam longint CycleLimit = 2000000;

    logic               clk;
    logic               rst_n;
    logic               valid;
    logic               stall;
    logic [1:0]         req_type;
    logic [31:0]        time_now;
    logic [31:0]        pos_now;
    logic               mode;
    logic [31:0]        span_length;
    logic signed [23:0] current_lat;
    logic signed [23:0] target_lat;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] reference;
    logic               pending;
    logic               accepted;

    quintic_lane_change_trajectory uut (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .req_type(req_type), .time_now(time_now), .pos_now(pos_now),
        .mode(mode), .span_length(span_length), .current_lat(current_lat),
        .target_lat(target_lat), .out_valid(out_valid), .out_stall(out_stall),
        .reference(reference), .pending(pending), .accepted(accepted)
    );

    // Predictor state: a private copy of everything the block remembers.
    logic               p_busy;
    logic               p_begun;
    logic               p_kind;
    logic [31:0]        p_start;
    logic [31:0]        p_span;
    logic [32:0]        p_end;
    logic signed [23:0] p_lat_start;
    logic signed [23:0] p_lat_end;
    logic signed [23:0] p_hold;

    lane_cmd_t pending_cmds[$];
    lane_ref_t expected_refs[$];
    int        errors;
    int        results_seen;
    int        changes_taken;
    int        rejects_seen;
    int        completions_seen;
    longint    cycles;
    bit        stimulus_done;
    bit        sender_hold;     // the sender pauses while this is set
    bit        receiver_hold;   // the long receiver back-pressure window
    int        in_gap;
    int        out_gap;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Quintic blend evaluated in the same fixed-point steps as the block:
    // s in Q0.32, s^2 and s^3 truncated, the inner polynomial truncated to
    // Q.28, and the final offset rounded half away from zero.
    function automatic logic signed [23:0] quintic_blend(input logic [31:0] elapsed);
        logic [63:0]  s;
        logic [63:0]  s2;
        logic [63:0]  s3;
        logic [63:0]  p;
        logic [127:0] h;
        logic [63:0]  mag;
        logic [127:0] q;
        longint       delta;
        longint       r;
        if (p_span == 0)
            return p_lat_start;
        s = ({elapsed, 32'd0}) / {32'd0, p_span};
        if (s > 64'hFFFF_FFFF)
            s = 64'hFFFF_FFFF;
        s2 = (s * s) >> 32;
        s3 = (s2 * s) >> 32;
        p = (64'd10 << 32) + 64'd6 * s2 - 64'd15 * s;
        h = ({64'd0, s3} * {64'd0, p >> 4}) >> 28;
        if (h > (128'd1 << 32))
            h = 128'd1 << 32;
        delta = longint'(p_lat_end) - longint'(p_lat_start);
        mag = (delta < 0) ? 64'(-delta) : 64'(delta);
        q = ({64'd0, mag} * h + (128'd1 << 31)) >> 32;
        r = longint'(p_lat_start) + ((delta < 0) ? -longint'(q) : longint'(q));
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return 24'(r);
    endfunction

    // Advances the predictor by one transaction and returns its result.
    function automatic lane_ref_t predict_reference(input lane_cmd_t c);
        lane_ref_t   o;
        logic [31:0] var_now;
        o.acc = 1'b0;
        case (c.req)
            REQ_TICK:
            begin
                if (p_busy)
                begin
                    var_now = p_kind ? c.t_now : c.x_now;
                    p_hold = p_lat_start;
                    if (!p_begun && var_now >= p_start)
                        p_begun = 1'b1;
                    if ({1'b0, var_now} >= p_end)
                    begin
                        p_busy = 1'b0;
                        p_hold = p_lat_end;
                        completions_seen++;
                    end
                    else if (p_begun)
                        p_hold = quintic_blend((var_now >= p_start) ? var_now - p_start : 32'd0);
                end
            end
            REQ_CHANGE:
            begin
                if (!p_busy && c.len != 0)
                begin
                    o.acc = 1'b1;
                    p_busy = 1'b1;
                    p_begun = 1'b0;
                    p_kind = c.md;
                    p_start = c.md ? c.t_now : c.x_now;
                    p_span = c.len;
                    p_end = {1'b0, p_start} + {1'b0, c.len};
                    p_lat_start = c.cur;
                    p_lat_end = c.tgt;
                    p_hold = c.cur;
                    changes_taken++;
                end
                else
                    rejects_seen++;
            end
            REQ_ABORT:
            begin
                p_busy = 1'b0;
                p_hold = p_lat_start;
            end
            default:
            begin
            end
        endcase
        o.ref_lat = p_hold;
        o.pend = p_busy;
        return o;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    function automatic logic signed [23:0] rand_lat();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'(signed'($urandom_range(1600000)) - 800000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic lane_cmd_t make_cmd(input req_t r, input logic [31:0] t,
                                           input logic [31:0] x, input logic md,
                                           input logic [31:0] len,
                                           input logic signed [23:0] cur,
                                           input logic signed [23:0] tgt);
        lane_cmd_t c;
        c.req = r;
        c.t_now = t;
        c.x_now = x;
        c.md = md;
        c.len = len;
        c.cur = cur;
        c.tgt = tgt;
        return c;
    endfunction

    // Queues one well-formed lane change: a request, a walk of ticks across
    // the span with occasional steps backward, and either the end or an abort.
    task automatic queue_maneuver();
        logic [31:0]        base;
        logic [31:0]        len;
        logic [31:0]        cur;
        logic               md;
        logic signed [23:0] a;
        logic signed [23:0] b;
        int                 steps;
        md = 1'($urandom_range(1));
        a = rand_lat();
        b = rand_lat();
        case ($urandom_range(3))
            0: len = $urandom_range(64, 1);
            1: len = $urandom_range(32'h0010_0000, 32'h0001_0000);
            default: len = $urandom_range(32'h00A0_0000, 32'h0000_8000);
        endcase
        base = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(50000) : $urandom;
        pending_cmds.push_back(make_cmd(REQ_CHANGE, md ? base : $urandom,
                                        md ? $urandom : base, md, len, a, b));
        steps = $urandom_range(12, 3);
        cur = base;
        for (int i = 0; i < steps; i++)
        begin
            if ($urandom_range(9) == 0)
                cur = base - $urandom_range(3000);
            else
                cur = base + 32'((64'(len) * (i + 1)) / steps);
            pending_cmds.push_back(make_cmd(REQ_TICK, md ? cur : $urandom,
                                            md ? $urandom : cur, 1'($urandom), $urandom,
                                            24'($urandom), 24'($urandom)));
        end
        if ($urandom_range(4) == 0)
            pending_cmds.push_back(make_cmd(REQ_ABORT, $urandom, $urandom, 1'($urandom),
                                            $urandom, 24'($urandom), 24'($urandom)));
        else
            pending_cmds.push_back(make_cmd(REQ_TICK, md ? base + len : $urandom,
                                            md ? $urandom : base + len, 1'b0, 32'd0,
                                            '0, '0));
    endtask

    task automatic queue_noise();
        lane_cmd_t c;
        c.req = req_t'(2'($urandom_range(3)));
        c.t_now = $urandom;
        c.x_now = $urandom;
        c.md = 1'($urandom);
        c.len = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
        c.cur = 24'($urandom);
        c.tgt = 24'($urandom);
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || valid || expected_refs.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus: directed corners first, then mostly whole maneuvers with noise.
    initial
    begin
        sender_hold = 1'b0;
        receiver_hold = 1'b0;
        stimulus_done = 1'b0;
        wait (rst_n === 1'b1);
        // Idle tick, abort while idle, and an unused code before any request.
        pending_cmds.push_back(make_cmd(REQ_TICK, '0, '0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(REQ_ABORT, '0, '0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(REQ_UNUSED, '1, '1, 1'b1, '1, '1, '1));
        // Zero span is rejected.
        pending_cmds.push_back(make_cmd(REQ_CHANGE, 32'd100, 32'd100, 1'b1, '0,
                                        24'sd5, 24'sd6));
        // Time-based change from the negative extreme to the positive extreme.
        pending_cmds.push_back(make_cmd(REQ_CHANGE, 32'h0001_0000, '0, 1'b1, 32'h0004_0000,
                                        24'sh800000, 24'sh7FFFFF));
        // Second request while pending is rejected.
        pending_cmds.push_back(make_cmd(REQ_CHANGE, '0, '0, 1'b1, 32'd1, 24'sd1, 24'sd1));
        // Tick before the span opens.
        pending_cmds.push_back(make_cmd(REQ_TICK, 32'h0000_8000, '0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(REQ_TICK, 32'h0002_0000, '0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(REQ_TICK, 32'h0003_0000, '0, 1'b0, '0, '0, '0));
        // Falls back below the start once the span opened.
        pending_cmds.push_back(make_cmd(REQ_TICK, 32'h0000_0001, '0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(REQ_TICK, 32'h0005_0000, '0, 1'b0, '0, '0, '0));
        // Distance-based change whose end lies beyond 32 bits; only abort ends it.
        pending_cmds.push_back(make_cmd(REQ_CHANGE, '0, 32'hFFFF_FF00, 1'b0, 32'hFFFF_FFFF,
                                        24'sh7FFFFF, 24'sh800000));
        pending_cmds.push_back(make_cmd(REQ_TICK, '0, 32'hFFFF_FFFF, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(REQ_TICK, '0, 32'h0000_0000, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(REQ_ABORT, '0, '0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(REQ_UNUSED, '0, '0, 1'b0, '0, '0, '0));
        // Span of one unit with time, position and start lateral at their maximum.
        pending_cmds.push_back(make_cmd(REQ_CHANGE, '1, '1, 1'b1, 32'd1, 24'sh7FFFFF, '0));
        pending_cmds.push_back(make_cmd(REQ_TICK, '1, '1, 1'b1, '1, '1, '1));
        wait_drained();

        // A long receiver stall while the sender keeps pushing so the input side
        // backs up, then the sender pauses with nothing in flight.
        repeat (20) queue_maneuver();
        while (pending_cmds.size() > 1000 - 200)
            @(posedge clk);
        receiver_hold = 1'b1;
        repeat (400) @(posedge clk);
        receiver_hold = 1'b0;
        wait_drained();
        sender_hold = 1'b1;
        repeat (30) @(posedge clk);
        sender_hold = 1'b0;

        while (results_seen + expected_refs.size() + pending_cmds.size() < 950)
        begin
            if ($urandom_range(4) == 0)
                queue_noise();
            else
                queue_maneuver();
            while (pending_cmds.size() > 40)
                @(posedge clk);
        end
        wait_drained();
        stimulus_done = 1'b1;
    end

    // Driver: offers queued transactions with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid <= 1'b0;
            req_type <= REQ_TICK;
            time_now <= '0;
            pos_now <= '0;
            mode <= 1'b0;
            span_length <= '0;
            current_lat <= '0;
            target_lat <= '0;
            in_gap <= 0;
        end
        else if (!(valid && stall))
        begin
            if (valid)
                expected_refs.push_back(predict_reference(pending_cmds.pop_front()));
            if (in_gap > 0)
            begin
                valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (!sender_hold && pending_cmds.size() != 0)
            begin
                lane_cmd_t c;
                c = pending_cmds[0];
                valid <= 1'b1;
                req_type <= c.req;
                time_now <= c.t_now;
                pos_now <= c.x_now;
                mode <= c.md;
                span_length <= c.len;
                current_lat <= c.cur;
                target_lat <= c.tgt;
                in_gap <= pick_gap();
            end
            else
                valid <= 1'b0;
        end
    end

    // Monitor and checker: random stalls, then compares each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                lane_ref_t e;
                results_seen <= results_seen + 1;
                if (expected_refs.size() == 0)
                begin
                    $error("unexpected result transaction: reference %0d", reference);
                    errors++;
                end
                else
                begin
                    e = expected_refs.pop_front();
                    if (reference !== e.ref_lat)
                    begin
                        $error("reference: expected %0d, got %0d", e.ref_lat, reference);
                        errors++;
                    end
                    if (pending !== e.pend)
                    begin
                        $error("pending: expected %0b, got %0b", e.pend, pending);
                        errors++;
                    end
                    if (accepted !== e.acc)
                    begin
                        $error("accepted: expected %0b, got %0b", e.acc, accepted);
                        errors++;
                    end
                end
            end
            if (receiver_hold)
                out_stall <= 1'b1;
            else if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(3) == 0)
                    out_gap <= pick_gap();
            end
        end
    end

    // Reset, watchdog and the final verdict.
    initial
    begin
        errors = 0;
        cycles = 0;
        completions_seen = 0;
        changes_taken = 0;
        rejects_seen = 0;
        p_busy = 1'b0;
        p_begun = 1'b0;
        p_kind = 1'b0;
        p_start = '0;
        p_span = '0;
        p_end = '0;
        p_lat_start = '0;
        p_lat_end = '0;
        p_hold = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (!stimulus_done && cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        if (!stimulus_done)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            // Allow a margin for a running tick to finish.
            repeat (100) @(posedge clk);
            if (expected_refs.size() != 0)
            begin
                $error("%0d result transactions never arrived", expected_refs.size());
                errors++;
            end
            $display("Checked %0d results: %0d changes accepted, %0d requests rejected,",
                     results_seen, changes_taken, rejects_seen);
            $display("%0d changes ran to the target, %0d mismatches.",
                     completions_seen, errors);
            if (errors == 0)
                $display("SUCCESS");
            else
                $display("FAILURE");
            $finish;
        end
    end

endmodule
